// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the checker file rbsi_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rbsi_pkg.sv -----
`default_nettype none
package rbsi_pkg;
    localparam int DATA_W   = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 65;
    localparam int NUM_AXES = 3;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] near_t;
        logic signed [DATA_W-1:0] far_t;
    } t_slab;

    // saturate a magnitude with sign into signed 32-bit
    function automatic logic signed [DATA_W-1:0] sat_q(input logic [PROD_W-1:0] mag,
                                                       input logic neg);
        logic signed [DATA_W-1:0] res;
        if (neg) begin
            if (mag >= PROD_W'(64'h8000_0000)) begin
                res = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                res = -$signed(mag[DATA_W-1:0]);
            end
        end else begin
            if (mag >= PROD_W'(64'h7FFF_FFFF)) begin
                res = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                res = $signed(mag[DATA_W-1:0]);
            end
        end
        return res;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/rbsi_recip.sv -----
`default_nettype none
module rbsi_recip #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_dir,
    output logic                             o_vld,
    output logic [rbsi_pkg::DATA_W-1:0]      o_mag,
    output logic                             o_neg
);
    import rbsi_pkg::*;

    // quotient of 2^(2F) / |d|, one bit per stage
    localparam int QW = 2 * FRAC_BITS + 1;
    localparam int RW = DATA_W + 1;

    logic [RW-1:0]     w_rem  [QW+1];
    logic [QW-1:0]     w_quo  [QW+1];
    logic [DATA_W-1:0] w_div  [QW+1];
    logic              w_vld  [QW+1];
    logic              w_neg  [QW+1];
    logic              w_zero [QW+1];

    assign w_rem[0]  = '0;
    assign w_quo[0]  = '0;
    assign w_div[0]  = i_dir[DATA_W-1] ? DATA_W'(-i_dir) : DATA_W'(i_dir);
    assign w_vld[0]  = i_vld;
    assign w_neg[0]  = i_dir[DATA_W-1];
    assign w_zero[0] = (i_dir == '0);

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0]     r_rem;
        logic [QW-1:0]     r_quo;
        logic [DATA_W-1:0] r_div;
        logic              r_vld;
        logic              r_neg;
        logic              r_zero;
        logic [RW-1:0]     n_sh;
        logic              n_ge;

        // numerator has its only set bit at the top
        assign n_sh = {w_rem[k][RW-2:0], (k == 0) ? 1'b1 : 1'b0};
        assign n_ge = (n_sh >= {1'b0, w_div[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_ge ? (n_sh - {1'b0, w_div[k]}) : n_sh;
            r_quo  <= {w_quo[k][QW-2:0], n_ge};
            r_div  <= w_div[k];
            r_neg  <= w_neg[k];
            r_zero <= w_zero[k];
        end

        assign w_rem[k+1]  = r_rem;
        assign w_quo[k+1]  = r_quo;
        assign w_div[k+1]  = r_div;
        assign w_vld[k+1]  = r_vld;
        assign w_neg[k+1]  = r_neg;
        assign w_zero[k+1] = r_zero;
    end

    logic [PROD_W-1:0] w_q;
    logic [DATA_W-1:0] n_mag;
    logic              r_vld_o;
    logic [DATA_W-1:0] r_mag;
    logic              r_neg_o;

    assign w_q = PROD_W'(w_quo[QW]);

    always_comb begin
        if (w_zero[QW]) begin
            n_mag = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_neg[QW]) begin
            n_mag = (w_q >= PROD_W'(64'h8000_0000)) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                    : w_q[DATA_W-1:0];
        end else begin
            n_mag = (w_q >= PROD_W'(64'h7FFF_FFFF)) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                    : w_q[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else begin
            r_vld_o <= w_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        // a zero reciprocal counts as non-negative
        r_neg_o <= w_neg[QW] && !w_zero[QW] && (n_mag != '0);
    end

    assign o_vld = r_vld_o;
    assign o_mag = r_mag;
    assign o_neg = r_neg_o;
endmodule
`default_nettype wire

// ----- rtl/core/rbsi_lane.sv -----
`default_nettype none
module rbsi_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_vld,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_origin,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_dir,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_lo,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_hi,
    output logic                                    o_vld,
    output rbsi_pkg::t_slab                         o_slab
);
    import rbsi_pkg::*;

    localparam int QW   = 2 * FRAC_BITS + 1;
    localparam int HW   = DATA_W / 2;
    localparam int PP_W = DIFF_W + HW;

    logic              rc_vld;
    logic [DATA_W-1:0] rc_mag;
    logic              rc_neg;

    rbsi_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_vld),
        .i_dir  (i_dir),
        .o_vld  (rc_vld),
        .o_mag  (rc_mag),
        .o_neg  (rc_neg)
    );

    logic signed [DIFF_W-1:0] n_d0;
    logic signed [DIFF_W-1:0] n_d1;

    assign n_d0 = DIFF_W'(i_lo) - DIFF_W'(i_origin);
    assign n_d1 = DIFF_W'(i_hi) - DIFF_W'(i_origin);

    // face distances wait alongside the divider
    logic [DIFF_W-1:0] r_m0 [QW+1];
    logic [DIFF_W-1:0] r_m1 [QW+1];
    logic              r_s0 [QW+1];
    logic              r_s1 [QW+1];

    always_ff @(posedge i_clk) begin
        r_m0[0] <= n_d0[DIFF_W-1] ? DIFF_W'(-n_d0) : DIFF_W'(n_d0);
        r_m1[0] <= n_d1[DIFF_W-1] ? DIFF_W'(-n_d1) : DIFF_W'(n_d1);
        r_s0[0] <= n_d0[DIFF_W-1];
        r_s1[0] <= n_d1[DIFF_W-1];
        for (int j = 1; j <= QW; j++) begin
            r_m0[j] <= r_m0[j-1];
            r_m1[j] <= r_m1[j-1];
            r_s0[j] <= r_s0[j-1];
            r_s1[j] <= r_s1[j-1];
        end
    end

    // partial products on the two halves of the reciprocal
    logic              r_pp_vld;
    logic [PP_W-1:0]   r_pl0;
    logic [PP_W-1:0]   r_ph0;
    logic [PP_W-1:0]   r_pl1;
    logic [PP_W-1:0]   r_ph1;
    logic              r_ng0;
    logic              r_ng1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
        end else begin
            r_pp_vld <= rc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl0 <= r_m0[QW] * rc_mag[HW-1:0];
        r_ph0 <= r_m0[QW] * rc_mag[DATA_W-1:HW];
        r_pl1 <= r_m1[QW] * rc_mag[HW-1:0];
        r_ph1 <= r_m1[QW] * rc_mag[DATA_W-1:HW];
        r_ng0 <= r_s0[QW] ^ rc_neg;
        r_ng1 <= r_s1[QW] ^ rc_neg;
    end

    logic [PROD_W-1:0] n_p0;
    logic [PROD_W-1:0] n_p1;

    assign n_p0 = (PROD_W'(r_pl0) + (PROD_W'(r_ph0) << HW)) >> FRAC_BITS;
    assign n_p1 = (PROD_W'(r_pl1) + (PROD_W'(r_ph1) << HW)) >> FRAC_BITS;

    logic                     r_t_vld;
    logic signed [DATA_W-1:0] r_t0;
    logic signed [DATA_W-1:0] r_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else begin
            r_t_vld <= r_pp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0 <= sat_q(n_p0, r_ng0 && (n_p0 != '0));
        r_t1 <= sat_q(n_p1, r_ng1 && (n_p1 != '0));
    end

    logic  r_o_vld;
    t_slab r_slab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_t0 < r_t1) begin
            r_slab.near_t <= r_t0;
            r_slab.far_t  <= r_t1;
        end else begin
            r_slab.near_t <= r_t1;
            r_slab.far_t  <= r_t0;
        end
    end

    assign o_vld  = r_o_vld;
    assign o_slab = r_slab;
endmodule
`default_nettype wire

// ----- rtl/core/rbsi_merge.sv -----
`default_nettype none
module rbsi_merge (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_vld,
    input  wire rbsi_pkg::t_slab                    i_slab [rbsi_pkg::NUM_AXES],
    output logic                                    o_done,
    output logic                                    o_hit,
    output logic signed [rbsi_pkg::DATA_W-1:0]      o_t_enter,
    output logic signed [rbsi_pkg::DATA_W-1:0]      o_t_exit
);
    import rbsi_pkg::*;

    logic signed [DATA_W-1:0] n_enter;
    logic signed [DATA_W-1:0] n_exit;

    always_comb begin
        n_enter = i_slab[0].near_t;
        n_exit  = i_slab[0].far_t;
        for (int a = 1; a < NUM_AXES; a++) begin
            if (i_slab[a].near_t > n_enter) begin
                n_enter = i_slab[a].near_t;
            end
            if (i_slab[a].far_t < n_exit) begin
                n_exit = i_slab[a].far_t;
            end
        end
    end

    logic                     r_vld;
    logic signed [DATA_W-1:0] r_enter;
    logic signed [DATA_W-1:0] r_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_enter <= n_enter;
        r_exit  <= n_exit;
    end

    logic                     r_done;
    logic                     r_hit;
    logic signed [DATA_W-1:0] r_o_enter;
    logic signed [DATA_W-1:0] r_o_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit     <= !r_exit[DATA_W-1] && !(r_enter > r_exit);
        r_o_enter <= r_enter;
        r_o_exit  <= r_exit;
    end

    assign o_done    = r_done;
    assign o_hit     = r_hit;
    assign o_t_enter = r_o_enter;
    assign o_t_exit  = r_o_exit;
endmodule
`default_nettype wire

// ----- rtl/core/ray_box_slab_intersection_unit.sv -----
// ray against axis-aligned box, slab test, fully pipelined
// start feeds three axis lanes (reciprocal divider, partial products, saturation, near/far sort) and a registered merge
// throughput: one ray per cycle; busy stays low, set by the bit-per-stage reciprocal divider
// the receiver cannot stall: each result shows on o_done for exactly one cycle
// synchronous active-low reset clears pipeline valids; box resets to [0, 1.0] on all axes
`default_nettype none
module ray_box_slab_intersection_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_cfg_we,
    input  wire logic [2:0]                         i_cfg_idx,
    input  wire logic [rbsi_pkg::DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_origin_x,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_origin_y,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_origin_z,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_dir_x,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_dir_y,
    input  wire logic signed [rbsi_pkg::DATA_W-1:0] i_dir_z,
    output logic                                    o_done,
    output logic                                    o_hit,
    output logic signed [rbsi_pkg::DATA_W-1:0]      o_t_enter,
    output logic signed [rbsi_pkg::DATA_W-1:0]      o_t_exit
);
    import rbsi_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    logic signed [DATA_W-1:0] r_lo [NUM_AXES];
    logic signed [DATA_W-1:0] r_hi [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= ONE;
            end
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MIN_X: r_lo[0] <= i_cfg_data;
                REG_MIN_Y: r_lo[1] <= i_cfg_data;
                REG_MIN_Z: r_lo[2] <= i_cfg_data;
                REG_MAX_X: r_hi[0] <= i_cfg_data;
                REG_MAX_Y: r_hi[1] <= i_cfg_data;
                REG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                     w_acc;
    logic signed [DATA_W-1:0] w_org [NUM_AXES];
    logic signed [DATA_W-1:0] w_dir [NUM_AXES];
    logic                     w_vld [NUM_AXES];
    t_slab                    w_slab [NUM_AXES];

    assign w_acc    = start && !busy;
    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_acc),
            .i_origin(w_org[a]),
            .i_dir   (w_dir[a]),
            .i_lo    (r_lo[a]),
            .i_hi    (r_hi[a]),
            .o_vld   (w_vld[a]),
            .o_slab  (w_slab[a])
        );
    end

    rbsi_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_vld[0] && w_vld[1] && w_vld[2]),
        .i_slab   (w_slab),
        .o_done   (o_done),
        .o_hit    (o_hit),
        .o_t_enter(o_t_enter),
        .o_t_exit (o_t_exit)
    );
endmodule
`default_nettype wire

// ----- rtl/core/rbsi_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module rbsi_checker #(
    parameter int FRAC_BITS = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic        o_hit,
    input wire logic [31:0] o_t_enter,
    input wire logic [31:0] o_t_exit
);
    localparam int LAT = 2 * FRAC_BITS + 7;

    logic w_order_ok;
    assign w_order_ok = !o_t_exit[31] && ($signed(o_t_enter) <= $signed(o_t_exit));

    `CHK_IMPL(a_hit_order, i_clk, i_rst_n, o_done && o_hit, w_order_ok, "hit with bad interval")
    `CHK_IMPL(a_miss_order, i_clk, i_rst_n, o_done && !o_hit, !w_order_ok, "miss with good interval")
    `CHK_IMPL(a_lat, i_clk, i_rst_n, start && !busy, ##LAT o_done, "request result missing")
    `CHK_IMPL(a_no_extra, i_clk, i_rst_n, o_done, $past(start, LAT), "result without request")
    `CHK_NEXT(a_never_busy, i_clk, i_rst_n, 1'b1, !busy, "busy raised")
endmodule

bind ray_box_slab_intersection_unit rbsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rbsi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_hit    (o_hit),
    .o_t_enter(o_t_enter),
    .o_t_exit (o_t_exit)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import rbsi_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 2 * FB + 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;
    localparam int RANDOM_RAYS = 880;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
    } t_ray;

    typedef struct {
        logic               hit;
        logic signed [31:0] t_enter;
        logic signed [31:0] t_exit;
    } t_isect;

    logic i_clk, i_rst_n, start, busy;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic signed [31:0] i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z;
    logic o_done, o_hit;
    logic signed [31:0] o_t_enter, o_t_exit;

    ray_box_slab_intersection_unit #(.FRAC_BITS(FB)) dut (.*);

    // box corners as the predictor sees them
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];

    t_ray   ray_q [$];
    t_isect isect_q [$];
    int     gap_pct;
    bit     failed;
    int     idle_cycles;
    bit     cfg_busy;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] sat_mag(logic [127:0] mag, logic neg);
        if (neg) return (mag >= 128'h8000_0000) ? MIN_Q : -$signed({1'b0, mag[31:0]});
        return (mag >= 128'h7FFF_FFFF) ? MAX_Q : $signed(mag[31:0]);
    endfunction

    function automatic logic signed [31:0] slope_inverse(logic signed [31:0] d);
        logic [63:0] m;
        if (d == 0) return MAX_Q;
        m = (d < 0) ? 64'(-64'(d)) : 64'(d);
        return sat_mag(128'((64'd1 << (2 * FB)) / m), d < 0);
    endfunction

    function automatic logic signed [31:0] face_dist(logic signed [32:0] diff,
                                                     logic signed [31:0] r);
        logic [127:0] dm, rm, p;
        dm = (diff < 0) ? 128'(-64'(diff)) : 128'(64'(diff));
        rm = (r < 0) ? 128'(-64'(r)) : 128'(64'(r));
        p = (dm * rm) >> FB;
        return sat_mag(p, ((diff < 0) != (r < 0)) && p != 0);
    endfunction

    function automatic t_isect slab_intersect(t_ray ray);
        t_isect res;
        logic signed [31:0] r, t0, t1, nv, fv;
        for (int a = 0; a < 3; a++) begin
            r  = slope_inverse(ray.dir[a]);
            t0 = face_dist(33'(box_lo[a]) - 33'(ray.org[a]), r);
            t1 = face_dist(33'(box_hi[a]) - 33'(ray.org[a]), r);
            nv = (t0 < t1) ? t0 : t1;
            fv = (t0 < t1) ? t1 : t0;
            if (a == 0 || nv > res.t_enter) res.t_enter = nv;
            if (a == 0 || fv < res.t_exit) res.t_exit = fv;
        end
        res.hit = !(res.t_exit < 0) && !(res.t_enter > res.t_exit);
        return res;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return MAX_Q;
            1: return MIN_Q;
            2: return 0;
            3: return $signed(32'($urandom_range(0, 8)) << FB) - (32'sd4 << FB);
            4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_ray rand_ray();
        t_ray ray;
        for (int a = 0; a < 3; a++) begin
            ray.org[a] = rand_q();
            ray.dir[a] = rand_q();
        end
        // mostly start the ray below the box's low corner, heading toward positive coordinates on every axis
        if ($urandom_range(0, 2) != 0) begin
            for (int a = 0; a < 3; a++) begin
                ray.org[a] = box_lo[a] - $signed($urandom_range(0, 32'h0004_0000));
                ray.dir[a] = $signed($urandom_range(1, 32'h0002_0000));
            end
        end
        return ray;
    endfunction

    task automatic cfg_write(t_reg_idx idx, logic signed [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx <= REG_MIN_Z) box_lo[idx] = val;
        else box_hi[idx - REG_MAX_X] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(logic signed [31:0] lo, logic signed [31:0] hi);
        cfg_write(REG_MIN_X, lo);
        cfg_write(REG_MIN_Y, lo);
        cfg_write(REG_MIN_Z, lo);
        cfg_write(REG_MAX_X, hi);
        cfg_write(REG_MAX_Y, hi);
        cfg_write(REG_MAX_Z, hi);
    endtask

    task automatic drain();
        wait (ray_q.size() == 0 && isect_q.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic push_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                            logic signed [31:0] oz, logic signed [31:0] dx,
                            logic signed [31:0] dy, logic signed [31:0] dz);
        t_ray ray;
        ray.org = '{ox, oy, oz};
        ray.dir = '{dx, dy, dz};
        ray_q.push_back(ray);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            isect_q.push_back(slab_intersect(ray_q.pop_front()));
        end
        if (i_rst_n && ray_q.size() > 0 && !cfg_busy && $urandom_range(0, 99) >= gap_pct) begin
            start      <= 1'b1;
            i_origin_x <= ray_q[0].org[0];
            i_origin_y <= ray_q[0].org[1];
            i_origin_z <= ray_q[0].org[2];
            i_dir_x    <= ray_q[0].dir[0];
            i_dir_y    <= ray_q[0].dir[1];
            i_dir_z    <= ray_q[0].dir[2];
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_isect exp_r;
            if (isect_q.size() == 0) begin
                $display("%0t: unexpected result hit=%0b enter=%0d exit=%0d",
                         $time, o_hit, o_t_enter, o_t_exit);
                failed = 1'b1;
            end else begin
                exp_r = isect_q.pop_front();
                if (o_hit !== exp_r.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, o_hit);
                    failed = 1'b1;
                end
                if (o_t_enter !== exp_r.t_enter) begin
                    $display("%0t: t_enter expected %0d actual %0d",
                             $time, exp_r.t_enter, o_t_enter);
                    failed = 1'b1;
                end
                if (o_t_exit !== exp_r.t_exit) begin
                    $display("%0t: t_exit expected %0d actual %0d",
                             $time, exp_r.t_exit, o_t_exit);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || cfg_busy || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (ray_q.size() > 0 || isect_q.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic signed [31:0] one;
        one = 32'sh0001_0000;
        failed = 1'b0; idle_cycles = 0; gap_pct = 21; cfg_busy = 1'b0;
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        box_lo = '{0, 0, 0};
        box_hi = '{one, one, one};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rays against the reset box
        push_ray(-one, one / 2, one / 2, one, 0, 0);
        push_ray(one / 2, one / 2, one / 2, 0, 0, 0);
        push_ray(2 * one, one / 2, one / 2, -one, 0, 0);
        push_ray(2 * one, one / 2, one / 2, one, 0, 0);
        push_ray(-one, -one, -one, one, one, one);
        push_ray(-one, 5 * one, 0, one, 0, 0);
        push_ray(MAX_Q, MAX_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q);
        push_ray(MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q);
        push_ray(MIN_Q, MAX_Q, 0, 1, -1, 32'sh7FFF_FFFF);
        push_ray(0, 0, 0, -1, 1, MIN_Q);
        push_ray(one / 2, one / 2, one / 2, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        push_ray(-one, one / 4, one / 4, one, 1, -1);
        drain();

        // inverted box: corners swapped
        cfg_busy = 1'b1;
        set_box(one, 0);
        cfg_busy = 1'b0;
        push_ray(-one, one / 2, one / 2, one, 0, 0);
        push_ray(one / 2, one / 2, 2 * one, 0, 0, -one);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            cfg_busy = 1'b1;
            case (phase)
                0: set_box(MIN_Q, MAX_Q);
                1: set_box(-3 * one, 2 * one);
                2: begin
                    for (int r = 0; r <= REG_MAX_Z; r++) cfg_write(t_reg_idx'(r), rand_q());
                end
                default: set_box(-one, one);
            endcase
            gap_pct = (phase == 0) ? 21 : (phase == 1) ? 78 : 0;
            cfg_busy = 1'b0;
            for (int n = 0; n < RANDOM_RAYS / 4; n++) ray_q.push_back(rand_ray());
            drain();
        end

        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_recip.sv
rtl/core/rbsi_lane.sv
rtl/core/rbsi_merge.sv
rtl/core/ray_box_slab_intersection_unit.sv
rtl/core/rbsi_checker.sv
tb/sv/tb.sv
